@@ hw/rtl/sqr_pkg.sv @@
// Shared types and codes for the sorted request queue.
package sqr_pkg;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_POP    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_MATCH = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD_NEW,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_cmd_type;

   typedef struct packed {
      logic         capture;
      cell_cmd_type cmd;
   } cell_ctrl_type;

   typedef struct packed {
      logic [30:0] key;
      logic [31:0] rtime;
      logic [31:0] lamport;
      logic [15:0] mission;
   } rec_body_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  req_id;
      logic [15:0] req_mission;
      logic [31:0] req_lamport;
      logic [31:0] req_time;
      logic [30:0] req_key;
   } req_payload_type;

   typedef struct packed {
      logic        head_valid;
      logic [7:0]  head_id;
      logic [15:0] head_mission;
      logic [31:0] head_lamport;
      logic [31:0] head_time;
      logic [30:0] head_key;
      logic [4:0]  occupancy;
      logic [1:0]  status;
   } rsp_payload_type;

endpackage

@@ hw/rtl/sqr_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface sqr_req_if;
   logic                     valid;
   logic                     ready;
   sqr_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sqr_rsp_if;
   logic                     valid;
   logic                     ready;
   sqr_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/sqr_cell.sv @@
// One queue slot: holds a record, compares against a probe, shifts with its neighbours.
module sqr_cell #(
   parameter int ID_BITS = 8
) (
   input  logic                  clock,
   input  sqr_pkg::cell_ctrl_type ctrl,
   input  logic                  is_valid,
   input  logic [30:0]           probe_key,
   input  logic [31:0]           probe_time,
   input  logic [ID_BITS-1:0]    probe_id,
   input  sqr_pkg::rec_body_type new_body,
   input  logic [ID_BITS-1:0]    new_id,
   input  sqr_pkg::rec_body_type left_body,
   input  logic [ID_BITS-1:0]    left_id,
   input  sqr_pkg::rec_body_type right_body,
   input  logic [ID_BITS-1:0]    right_id,
   output sqr_pkg::rec_body_type body,
   output logic [ID_BITS-1:0]    id,
   output sqr_pkg::rec_body_type nxt_body,
   output logic [ID_BITS-1:0]    nxt_id,
   output logic                  ins_flag,
   output logic                  del_match
);

   sqr_pkg::rec_body_type body_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic                  ins_ff;
   logic                  match_ff;
   logic                  probe_before;
   logic                  ins_in;
   logic                  match_in;

   // probe sorts strictly before the held record
   always_comb begin
      if (probe_key != body_ff.key) begin
         probe_before = probe_key < body_ff.key;
      end else if (probe_time != body_ff.rtime) begin
         probe_before = probe_time < body_ff.rtime;
      end else begin
         probe_before = probe_id < id_ff;
      end
      ins_in   = !is_valid || probe_before;
      match_in = is_valid && (id_ff == probe_id) && (body_ff.rtime == probe_time);
   end

   always_comb begin
      case (ctrl.cmd)
         sqr_pkg::CELL_LOAD_NEW: begin
            nxt_body = new_body;
            nxt_id   = new_id;
         end
         sqr_pkg::CELL_FROM_LEFT: begin
            nxt_body = left_body;
            nxt_id   = left_id;
         end
         sqr_pkg::CELL_FROM_RIGHT: begin
            nxt_body = right_body;
            nxt_id   = right_id;
         end
         default: begin
            nxt_body = body_ff;
            nxt_id   = id_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      body_ff <= nxt_body;
      id_ff   <= nxt_id;
      if (ctrl.capture) begin
         ins_ff   <= ins_in;
         match_ff <= match_in;
      end
   end

   assign body      = body_ff;
   assign id        = id_ff;
   assign ins_flag  = ins_ff;
   assign del_match = match_ff;

endmodule

@@ hw/rtl/sorted_request_queue_unit.sv @@
// Sorted request queue top level: a chain of record cells and the operation sequencer.
//
//  channel  dir  handshake            carries
//  req_ch   in   valid/ready          kind, id, mission, lamport, time, key
//  rsp_ch   out  valid/ready          head record, occupancy, status
//
// In each transaction the accept edge registers the compare and match flags in
// every cell, and the shift edge then shifts the cells and loads the response.
// The shift edge waits while an earlier response is still unread; a new request is
// taken once the shift has happened, even if that response is still held.
// Synchronous reset empties the queue; slot contents are left as they are.
module sorted_request_queue_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input logic      clock,
   input logic      reset,
   sqr_req_if.sink  req_ch,
   sqr_rsp_if.source rsp_ch
);

   localparam int CountW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      PH_IDLE,
      PH_EXEC
   } phase_type;

   phase_type                 phase_ff;
   logic [CountW-1:0]         count_ff;
   logic [CountW-1:0]         count_in;
   logic                      rsp_valid_ff;
   sqr_pkg::rsp_payload_type  rsp_payload_ff;
   sqr_pkg::rsp_payload_type  rsp_payload_in;
   logic [1:0]                kind_ff;
   sqr_pkg::rec_body_type     new_body_ff;
   logic [ID_BITS-1:0]        new_id_ff;

   logic                      accept;
   logic                      exec_fire;
   logic [ID_BITS+7:0]        req_id_wide;
   logic [ID_BITS-1:0]        probe_id;
   sqr_pkg::rec_body_type     probe_body;

   sqr_pkg::rec_body_type     cell_body [QUEUE_DEPTH];
   logic [ID_BITS-1:0]        cell_id   [QUEUE_DEPTH];
   sqr_pkg::rec_body_type     cell_nxt_body [QUEUE_DEPTH];
   logic [ID_BITS-1:0]        cell_nxt_id   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]    ins_flag;
   logic [QUEUE_DEPTH-1:0]    del_match;
   logic [QUEUE_DEPTH-1:0]    del_prefix;
   logic [QUEUE_DEPTH-1:0]    cell_valid;
   sqr_pkg::cell_ctrl_type    cell_ctrl [QUEUE_DEPTH];

   logic                      is_full;
   logic                      do_insert;
   logic                      do_delete;
   logic                      do_pop;
   sqr_pkg::status_type       status_in;
   logic [ID_BITS+7:0]        head_id_wide;
   logic [CountW+4:0]         occ_wide;

   assign accept    = req_ch.valid && req_ch.ready;
   assign exec_fire = (phase_ff == PH_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_id_wide = {{ID_BITS{1'b0}}, req_ch.payload.req_id};
   assign probe_id    = req_id_wide[ID_BITS-1:0];
   always_comb begin
      probe_body.key     = req_ch.payload.req_key;
      probe_body.rtime   = req_ch.payload.req_time;
      probe_body.lamport = req_ch.payload.req_lamport;
      probe_body.mission = req_ch.payload.req_mission;
   end

   assign is_full   = count_ff == CountW'(QUEUE_DEPTH);
   assign do_insert = (kind_ff == sqr_pkg::KIND_INSERT) && !is_full;
   assign do_delete = (kind_ff == sqr_pkg::KIND_DELETE) && del_prefix[QUEUE_DEPTH-1];
   assign do_pop    = (kind_ff == sqr_pkg::KIND_POP) && (count_ff != '0);

   // cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      sqr_pkg::rec_body_type left_body;
      logic [ID_BITS-1:0]    left_id;
      sqr_pkg::rec_body_type right_body;
      logic [ID_BITS-1:0]    right_id;
      logic                  left_ins;

      assign cell_valid[i] = CountW'(i) < count_ff;

      if (i == 0) begin : g_first
         assign left_body     = new_body_ff;
         assign left_id       = new_id_ff;
         assign left_ins      = 1'b0;
         assign del_prefix[i] = del_match[i];
      end else begin : g_inner
         assign left_body     = cell_body[i-1];
         assign left_id       = cell_id[i-1];
         assign left_ins      = ins_flag[i-1];
         assign del_prefix[i] = del_prefix[i-1] | del_match[i];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_body = cell_body[i];
         assign right_id   = cell_id[i];
      end else begin : g_mid
         assign right_body = cell_body[i+1];
         assign right_id   = cell_id[i+1];
      end

      always_comb begin
         cell_ctrl[i].capture = accept;
         cell_ctrl[i].cmd     = sqr_pkg::CELL_HOLD;
         if (exec_fire) begin
            if (do_insert && ins_flag[i]) begin
               cell_ctrl[i].cmd = left_ins ? sqr_pkg::CELL_FROM_LEFT
                                           : sqr_pkg::CELL_LOAD_NEW;
            end else if ((do_delete && del_prefix[i]) || do_pop) begin
               cell_ctrl[i].cmd = sqr_pkg::CELL_FROM_RIGHT;
            end
         end
      end

      sqr_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .is_valid   (cell_valid[i]),
         .probe_key  (req_ch.payload.req_key),
         .probe_time (req_ch.payload.req_time),
         .probe_id   (probe_id),
         .new_body   (new_body_ff),
         .new_id     (new_id_ff),
         .left_body  (left_body),
         .left_id    (left_id),
         .right_body (right_body),
         .right_id   (right_id),
         .body       (cell_body[i]),
         .id         (cell_id[i]),
         .nxt_body   (cell_nxt_body[i]),
         .nxt_id     (cell_nxt_id[i]),
         .ins_flag   (ins_flag[i]),
         .del_match  (del_match[i])
      );
   end

   // status, occupancy and new head
   always_comb begin
      status_in = sqr_pkg::STATUS_OK;
      count_in  = count_ff;
      case (kind_ff)
         sqr_pkg::KIND_INSERT: begin
            if (is_full) begin
               status_in = sqr_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         sqr_pkg::KIND_DELETE: begin
            if (do_delete) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = sqr_pkg::STATUS_NO_MATCH;
            end
         end
         sqr_pkg::KIND_POP: begin
            if (do_pop) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = sqr_pkg::STATUS_EMPTY;
            end
         end
         default: begin
            status_in = sqr_pkg::STATUS_OK;
         end
      endcase

      head_id_wide = {8'b0, cell_nxt_id[0]};
      occ_wide     = {5'b0, count_in};

      rsp_payload_in.head_valid   = count_in != '0;
      rsp_payload_in.head_id      = head_id_wide[7:0];
      rsp_payload_in.head_mission = cell_nxt_body[0].mission;
      rsp_payload_in.head_lamport = cell_nxt_body[0].lamport;
      rsp_payload_in.head_time    = cell_nxt_body[0].rtime;
      rsp_payload_in.head_key     = cell_nxt_body[0].key;
      if (count_in == '0) begin
         rsp_payload_in.head_id      = '0;
         rsp_payload_in.head_mission = '0;
         rsp_payload_in.head_lamport = '0;
         rsp_payload_in.head_time    = '0;
         rsp_payload_in.head_key     = '0;
      end
      rsp_payload_in.occupancy = occ_wide[4:0];
      rsp_payload_in.status    = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (accept) begin
                  phase_ff <= PH_EXEC;
               end
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            PH_EXEC: begin
               if (exec_fire) begin
                  phase_ff     <= PH_IDLE;
                  count_ff     <= count_in;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_ch.payload.kind;
         new_body_ff <= probe_body;
         new_id_ff   <= probe_id;
      end
      if (exec_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign req_ch.ready   = (phase_ff == PH_IDLE) && !reset;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_head_matches_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.head_valid == (count_ff != '0)))
      else $error("head valid disagrees with count");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (exec_fire && (kind_ff == sqr_pkg::KIND_INSERT) && !is_full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the queue");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_payload_ff.status == sqr_pkg::STATUS_FULL))
      |-> (count_ff == CountW'(QUEUE_DEPTH)))
      else $error("full status on a queue with room");

endmodule
